[hdl/deq_pkg.sv]
// Shared types and codes for the double-ended queue.
// Request and response structs, request kinds, status codes, default depth.
// No dependencies.
package deq_pkg;

    localparam int DEFAULT_DEPTH = 1024;
    localparam int VAL_W         = 32;
    localparam int OCC_W         = 11;
    localparam int REQ_W         = 3;
    localparam int ST_W          = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SIZE       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_EMPTY      = 3'd5;
    localparam logic [REQ_W-1:0] REQ_FRONT      = 3'd6;
    localparam logic [REQ_W-1:0] REQ_BACK       = 3'd7;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic        [REQ_W-1:0] req_type;
        logic signed [VAL_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic        [OCC_W-1:0] occupancy;
        logic                    is_empty;
        logic        [ST_W-1:0]  status;
    } t_rsp;

    // Response fields known at accept time; read data joins when the response register loads.
    typedef struct packed {
        logic [OCC_W-1:0] occupancy;
        logic             is_empty;
        logic [ST_W-1:0]  status;
        logic             use_rdata;
    } t_meta;

endpackage

[hdl/double_ended_queue_top.sv]
// Double-ended queue top level: request/response handshake and response register.
// Depends on deq_pkg, deq_ctrl and deq_store.
//
// Bounded deque of signed 32-bit words in a single-port memory of QUEUE_DEPTH
// entries. Every request (push or pop at either end, size, empty, peek at either
// end) returns exactly one response with the value read, the occupancy after the
// request, an empty flag and a status (overflow on a full push, underflow on an
// empty pop or peek; value reads as zero then). Pointers and count update at
// accept, so one request per cycle is sustained while responses are taken;
// the store's registered read completes at the accept edge and the response
// register loads when the pending request moves on, so a response is valid once
// that register is loaded. A response that waits on the output stalls at most
// one further request inside the block. The store needs no clearing pass: only
// entries that were written are ever read.
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                    acc;
    logic                    move;
    logic                    wr_en, rd_en;
    logic [AW-1:0]           addr;
    logic signed [VAL_W-1:0] wdata, rdata;
    t_meta                   meta;

    logic  r_pend, n_pend;
    t_meta r_meta;
    logic  r_out_valid, n_out_valid;
    t_rsp  r_out;

    assign move        = r_pend && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_pend || move;
    assign acc         = i_req_valid && o_req_ready;

    deq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_req   (i_req),
        .o_wr_en (wr_en),
        .o_rd_en (rd_en),
        .o_addr  (addr),
        .o_wdata (wdata),
        .o_meta  (meta)
    );

    deq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr_en (wr_en),
        .i_rd_en (rd_en),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_comb begin
        n_pend = r_pend;
        if (acc) begin
            n_pend = 1'b1;
        end else if (move) begin
            n_pend = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (move) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_meta <= meta;
        end
        if (move) begin
            r_out.read_value <= r_meta.use_rdata ? rdata : '0;
            r_out.occupancy  <= r_meta.occupancy;
            r_out.is_empty   <= r_meta.is_empty;
            r_out.status     <= r_meta.status;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`ifndef SYNTHESIS
    a_pend_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !move) |=> r_pend)
        else $error("pending request dropped");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !move) |-> !acc)
        else $error("request accepted over a stalled one");

    a_move_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> o_rsp_valid)
        else $error("response register not loaded");
`endif

endmodule

[hdl/deq_store.sv]
// Element store: single-port synchronous memory, registered read.
// Depends on deq_pkg for the word width.
module deq_store
    import deq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH,
    parameter int AW          = $clog2(QUEUE_DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_addr,
    input  logic signed [VAL_W-1:0] i_wdata,
    output logic signed [VAL_W-1:0] o_rdata
);

    logic signed [VAL_W-1:0] r_mem [QUEUE_DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/deq_ctrl.sv]
// Head/tail pointers and occupancy count; decodes a request into a store access.
// Depends on deq_pkg for request codes, status codes and t_meta.
module deq_ctrl
    import deq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH,
    parameter int AW          = $clog2(QUEUE_DEPTH),
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_acc,
    input  t_req                    i_req,
    output logic                    o_wr_en,
    output logic                    o_rd_en,
    output logic [AW-1:0]           o_addr,
    output logic signed [VAL_W-1:0] o_wdata,
    output t_meta                   o_meta
);

    localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    logic          full, empty;
    logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic          wr, rd;
    logic [AW-1:0] addr;
    logic [ST_W-1:0] status;

    assign full  = (r_count == CNT_FULL);
    assign empty = (r_count == '0);

    assign head_inc = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? PTR_LAST : r_head - 1'b1;
    assign tail_inc = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? PTR_LAST : r_tail - 1'b1;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        wr      = 1'b0;
        rd      = 1'b0;
        addr    = r_head;
        status  = ST_OK;
        unique case (i_req.req_type) inside
            REQ_PUSH_FRONT: begin
                if (full) begin
                    status = ST_OVERFLOW;
                end else begin
                    wr      = 1'b1;
                    addr    = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (full) begin
                    status = ST_OVERFLOW;
                end else begin
                    wr      = 1'b1;
                    addr    = r_tail;
                    n_tail  = tail_inc;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    status = ST_UNDERFLOW;
                end else begin
                    rd      = 1'b1;
                    addr    = r_head;
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    status = ST_UNDERFLOW;
                end else begin
                    rd      = 1'b1;
                    addr    = tail_dec;
                    n_tail  = tail_dec;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_FRONT: begin
                if (empty) begin
                    status = ST_UNDERFLOW;
                end else begin
                    rd   = 1'b1;
                    addr = r_head;
                end
            end
            REQ_BACK: begin
                if (empty) begin
                    status = ST_UNDERFLOW;
                end else begin
                    rd   = 1'b1;
                    addr = tail_dec;
                end
            end
            REQ_SIZE, REQ_EMPTY: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_acc) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_wr_en = i_acc && wr;
    assign o_rd_en = i_acc && rd;
    assign o_addr  = addr;
    assign o_wdata = i_req.push_value;

    assign o_meta.occupancy = OCC_W'(n_count);
    assign o_meta.is_empty  = (n_count == '0);
    assign o_meta.status    = status;
    assign o_meta.use_rdata = rd;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("occupancy count above depth");

    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_FULL) |-> r_head == r_tail)
        else $error("pointers disagree with empty or full count");

    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && status != ST_OK) |=>
            ($stable(r_head) && $stable(r_tail) && $stable(r_count)))
        else $error("refused request changed queue state");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en))
        else $error("read and write issued together");
`endif

endmodule
